// File: rtl/core/kmp_pkg.sv
// Shared constants, types and helpers for the KMP substring search core.
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 64;
    localparam int LEN_REG_W   = 4;

    localparam logic [CNT_W-1:0] LINK_NONE = '1;
    localparam logic [POS_W-1:0] POS_MAX   = '1;

    // register indexes, decoded from paddr[3]
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] pattern;
        logic [CNT_W-1:0]  len;      // effective length, 1..MAX_PATTERN
    } cfg_t;

    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_REG_W-1:0] raw);
        logic [CNT_W-1:0] n;
        if (raw == '0)
            n = CNT_W'(1);
        else if (raw > LEN_REG_W'(MAX_PATTERN))
            n = CNT_W'(MAX_PATTERN);
        else
            n = CNT_W'(raw);
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kmp_apb_regs.sv
// APB register block: pattern bytes and pattern length.
`default_nettype none

module kmp_apb_regs
    import kmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg,
    output logic                   cfg_wr
);

    logic [DATA_W-1:0]    pattern_reg;
    logic [LEN_REG_W-1:0] length_reg;
    logic                 reg_sel;

    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_REG_W'(1);
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_PATTERN)
                pattern_reg <= pwdata;
            else
                length_reg <= pwdata[LEN_REG_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_LENGTH) ? {{(DATA_W-LEN_REG_W){1'b0}}, length_reg}
                                            : pattern_reg;

    assign cfg.pattern = pattern_reg;
    assign cfg.len     = eff_len(length_reg);

endmodule

`default_nettype wire

// File: rtl/core/kmp_byte_cmp.sv
// Shared byte comparator: pattern byte A against pattern byte B or a text byte.
`default_nettype none

module kmp_byte_cmp
    import kmp_pkg::*;
(
    input  wire logic [DATA_W-1:0] pattern,
    input  wire logic [IDX_W-1:0]  idx_a,
    input  wire logic [IDX_W-1:0]  idx_b,
    input  wire logic              use_text,
    input  wire logic [7:0]        text,
    output logic                   eq
);

    logic [7:0] byte_a;
    logic [7:0] byte_b;

    assign byte_a = pattern[8*idx_a +: 8];
    assign byte_b = use_text ? text : pattern[8*idx_b +: 8];
    assign eq     = (byte_a == byte_b);

endmodule

`default_nettype wire

// File: rtl/core/kmp_link_ram.sv
// Failure link store; entry zero is always "no link".
`default_nettype none

module kmp_link_ram
    import kmp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [CNT_W-1:0] wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output logic      [CNT_W-1:0] rdata
);

    logic [CNT_W-1:0] mem_reg [1:MAX_PATTERN-1];

    always_ff @(posedge clk)
    begin
        if (we && (waddr != '0))
            mem_reg[waddr] <= wdata;
    end

    assign rdata = (raddr == '0) ? LINK_NONE : mem_reg[raddr];

endmodule

`default_nettype wire

// File: rtl/core/kmp_substring_search_core.sv
// Top level: KMP substring search with table build and search sequencer.
`default_nettype none

//  channel | dir  | handshake             | payload
//  --------+------+-----------------------+-----------------------------
//  input   | in   | in_valid / in_ready   | text_byte, last_byte
//  output  | out  | out_valid / out_ready | found, match_start
//  config  | APB  | psel/penable/pready   | pattern_bytes @0, length @8
//
//  Each text byte is accepted in ST_IDLE, compared in ST_CMP (one compare
//  per failure link walked, all through the single byte comparator) and
//  finished in ST_FIN; a byte that arrives after the match skips the compare.
//  After reset and after every register write the failure table is rebuilt
//  by the same comparator, in ST_B_ADV and ST_B_SET for each advance and in
//  ST_B_ADV alone for each link followed; in_ready is low meanwhile.
//  A result waiting in the output register does not block the next byte; the
//  finish cycle holds only if a new result finds the register still full.

module kmp_substring_search_core
    import kmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        text_byte,
    input  wire logic              last_byte,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [POS_W-1:0]  match_start,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // sequencer states
    localparam logic [2:0] ST_B_ADV = 3'd0;  // table build: advance or follow link
    localparam logic [2:0] ST_B_SET = 3'd1;  // table build: write one link
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;  // search: compare / walk links
    localparam logic [2:0] ST_FIN   = 3'd4;  // search: result and text end

    // saturating add for the candidate start position
    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] s,
                                                 input logic [CNT_W-1:0] d);
        logic [POS_W:0] sum;
        sum = {1'b0, s} + (POS_W+1)'(d);
        return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
    endfunction

    cfg_t             cfg;
    logic             cfg_wr;

    logic [2:0]       state_reg,   state_next;
    logic [CNT_W-1:0] j_reg,       j_next;        // pattern index (build j / search j)
    logic [IDX_W-1:0] k_reg,       k_next;        // build k
    logic             k_none_reg,  k_none_next;   // build k is -1
    logic [CNT_W-1:0] matched_reg, matched_next;
    logic [POS_W-1:0] start_reg,   start_next;
    logic             done_reg,    done_next;
    logic             hit_reg,     hit_next;
    logic [7:0]       byte_reg,    byte_next;
    logic             last_reg,    last_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg,   found_next;
    logic [POS_W-1:0] mstart_reg,  mstart_next;

    logic             link_we;
    logic [CNT_W-1:0] link_wdata;
    logic [IDX_W-1:0] link_raddr;
    logic [CNT_W-1:0] link_rdata;
    logic             cmp_use_text;
    logic             cmp_eq;
    logic             out_free;
    logic             emit;
    logic [CNT_W-1:0] j_inc;

    kmp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    // one comparator: build compares pat[j] with pat[k], search compares
    // pat[j] with the latched text byte
    assign cmp_use_text = (state_reg == ST_CMP);

    kmp_byte_cmp u_cmp (
        .pattern  (cfg.pattern),
        .idx_a    (j_reg[IDX_W-1:0]),
        .idx_b    (k_reg),
        .use_text (cmp_use_text),
        .text     (byte_reg),
        .eq       (cmp_eq)
    );

    assign link_raddr = (state_reg == ST_CMP) ? j_reg[IDX_W-1:0] : k_reg;

    kmp_link_ram u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (j_reg[IDX_W-1:0]),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign j_inc    = j_reg + CNT_W'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = hit_reg || (last_reg && !done_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        k_none_next    = k_none_reg;
        matched_next   = matched_reg;
        start_next     = start_reg;
        done_next      = done_reg;
        hit_next       = hit_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        mstart_next    = mstart_reg;
        link_we        = 1'b0;
        link_wdata     = cmp_eq ? link_rdata : CNT_W'(k_reg);

        case (state_reg)
            ST_B_ADV:
            begin
                if (j_inc >= cfg.len)
                    state_next = ST_IDLE;
                else if (k_none_reg || cmp_eq)
                begin
                    j_next      = j_inc;
                    k_next      = k_none_reg ? '0 : k_reg + IDX_W'(1);
                    k_none_next = 1'b0;
                    state_next  = ST_B_SET;
                end
                else if (link_rdata == LINK_NONE)
                    k_none_next = 1'b1;
                else
                    k_next = link_rdata[IDX_W-1:0];
            end

            ST_B_SET:
            begin
                // same byte at the fallback: inherit its link (optimized table)
                link_we    = 1'b1;
                state_next = ST_B_ADV;
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = text_byte;
                    last_next = last_byte;
                    hit_next  = 1'b0;
                    j_next    = (matched_reg >= cfg.len) ? '0 : matched_reg;
                    state_next = done_reg ? ST_FIN : ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (cmp_eq)
                begin
                    matched_next = j_inc;
                    hit_next     = (j_inc >= cfg.len);
                    state_next   = ST_FIN;
                end
                else if (link_rdata == LINK_NONE)
                begin
                    start_next   = pos_add(start_reg, j_inc);
                    matched_next = '0;
                    state_next   = ST_FIN;
                end
                else
                begin
                    start_next = pos_add(start_reg, j_reg - link_rdata);
                    j_next     = link_rdata;
                end
            end

            ST_FIN:
            begin
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = hit_reg;
                        mstart_next    = hit_reg ? start_reg : '0;
                    end
                    if (last_reg)
                    begin
                        matched_next = '0;
                        start_next   = '0;
                        done_next    = 1'b0;
                    end
                    else if (hit_reg)
                        done_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write: rebuild the table and restart the current text
        if (cfg_wr)
        begin
            state_next   = ST_B_ADV;
            j_next       = '0;
            k_next       = '0;
            k_none_next  = 1'b1;
            matched_next = '0;
            start_next   = '0;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_B_ADV;
            j_reg         <= '0;
            k_reg         <= '0;
            k_none_reg    <= 1'b1;
            matched_reg   <= '0;
            start_reg     <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            k_none_reg    <= k_none_next;
            matched_reg   <= matched_next;
            start_reg     <= start_next;
            done_reg      <= done_next;
            hit_reg       <= hit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        found_reg  <= found_next;
        mstart_reg <= mstart_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_start = mstart_reg;

endmodule

`default_nettype wire
